### design/pdl_pkg.sv
// Shared types and codes for the pooled doubly linked list manager.
// No dependencies.
package pdl_pkg;

  typedef enum logic [2:0] {
    KIND_ALLOC   = 3'd0,
    KIND_PREPEND = 3'd1,
    KIND_APPEND  = 3'd2,
    KIND_INS_BEF = 3'd3,
    KIND_INS_AFT = 3'd4,
    KIND_FREE    = 3'd5
  } kind_t;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_NOTGT = 2'd2;

  // One state per memory access.
  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_RD_HEAD,
    ST_RD_TGT,
    ST_DECIDE,
    ST_GET_R,
    ST_WALK,
    ST_WAIT_WALK,
    ST_RD_A,
    ST_RD_B,
    ST_WAIT_B,
    ST_WR_A,
    ST_WR_B,
    ST_WR_SELF,
    ST_OUT
  } state_t;

endpackage

### design/pooled_doubly_linked_list_manager.sv
// Pooled doubly linked list manager: fixed block pool, free list and caller lists.
// Depends on pdl_pkg and pdl_ram.
//
// Usage:
//   Request channel (valid, stall): kind, list_head_valid, list_head,
//   target_valid, target. Result channel (res_valid, res_stall): status,
//   granted_valid, granted, new_head_valid, new_head. One result per request.
//   Each block entry stores {in_use, prev, next} in one single-port RAM,
//   so every link read or write goes through that one port.
//   Requests that change nothing (free with no valid target, empty pool,
//   unknown kind) skip the link reads and writes; append first walks the
//   list from its head to find its tail. One request is worked at a time;
//   stall is high from acceptance until the result has moved into the
//   output register, so the next request can be taken in the same cycle
//   that the result appears.
//   Reset: a sweep writes every entry to chain the free list; stall stays
//   high until it ends.
//   While res_stall is high the result holds; a finished request waits in
//   the output state with stall high until the register frees.
module pooled_doubly_linked_list_manager #(
  parameter int POOL_BLOCKS = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  output logic       stall,
  input  logic [2:0] kind,
  input  logic       list_head_valid,
  input  logic [7:0] list_head,
  input  logic       target_valid,
  input  logic [7:0] target,
  output logic       res_valid,
  input  logic       res_stall,
  output logic [1:0] status,
  output logic       granted_valid,
  output logic [7:0] granted,
  output logic       new_head_valid,
  output logic [7:0] new_head
);
  import pdl_pkg::*;

  localparam int AW = $clog2(POOL_BLOCKS);
  localparam int LW = AW + 1;          // link with null flag in MSB
  localparam int EW = 2 * LW + 1;      // {in_use, prev, next}
  localparam int XW = AW + 9;          // wide enough for input index and pool size
  localparam logic [LW-1:0] NIL = {1'b1, {AW{1'b0}}};
  localparam logic [AW:0] LAST = (AW + 1)'(POOL_BLOCKS - 1);
  localparam logic [AW:0] WALK_MAX = (AW + 1)'(POOL_BLOCKS);

  function automatic logic [LW-1:0] lnk(input logic [AW-1:0] a);
    lnk = {1'b0, a};
  endfunction

  function automatic logic [7:0] to8(input logic [AW-1:0] a);
    logic [AW+7:0] w;
    w = {8'd0, a};
    to8 = w[7:0];
  endfunction

  state_t state, state_next;

  logic          we;
  logic [AW-1:0] addr;
  logic [EW-1:0] wdata, rdata;

  pdl_ram #(.WIDTH(EW), .DEPTH(POOL_BLOCKS)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic          rd_use;
  logic [LW-1:0] rd_prev, rd_next;
  assign rd_use  = rdata[EW-1];
  assign rd_prev = rdata[EW-2 -: LW];
  assign rd_next = rdata[LW-1:0];

  // request registers
  logic [2:0]    k;
  logic          hv_in, tv_in;
  logic [7:0]    h_in, t_in;
  logic          head_ok, tgt_ok;
  logic [LW-1:0] free_head;
  logic [AW-1:0] r;              // granted block
  logic [LW-1:0] n_of, p_of;     // neighbor links of the target
  logic [AW-1:0] cur;            // walk pointer
  logic [AW-1:0] tail;
  logic [AW:0]   steps;
  logic [AW:0]   sweep;
  logic [EW-1:0] a_ent, b_ent;   // neighbor entries read before the writes
  logic [1:0]    w_st;
  logic          w_gv, w_hv;
  logic [7:0]    w_g, w_h;
  logic          o_valid;

  logic [XW-1:0] hx, tx;
  logic [AW-1:0] head, tgt;
  logic          h_range, t_range, tgt_c;
  logic          is_free, is_cmd, eff_app, walk_end, out_go;

  assign hx      = {{(XW-8){1'b0}}, h_in};
  assign tx      = {{(XW-8){1'b0}}, t_in};
  assign head    = hx[AW-1:0];
  assign tgt     = tx[AW-1:0];
  assign h_range = (hx < XW'(POOL_BLOCKS));
  assign t_range = (tx < XW'(POOL_BLOCKS));
  assign tgt_c   = tv_in && t_range && rd_use;

  assign is_free  = (k == KIND_FREE);
  assign is_cmd   = (k <= KIND_INS_AFT);
  assign eff_app  = (k == KIND_APPEND) ||
                    (((k == KIND_INS_BEF) || (k == KIND_INS_AFT)) && !tgt_ok);
  assign walk_end = rd_next[LW-1] || ((steps + 1'b1) >= WALK_MAX);
  assign out_go   = (state == ST_OUT) && (!o_valid || !res_stall);

  assign stall     = (state != ST_IDLE);
  assign res_valid = o_valid;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_SWEEP:     if (sweep == LAST) state_next = ST_IDLE;
      ST_IDLE:      if (valid) state_next = ST_RD_HEAD;
      ST_RD_HEAD:   state_next = ST_RD_TGT;
      ST_RD_TGT:    state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (is_free) state_next = tgt_c ? ST_RD_A : ST_OUT;
        else if (!is_cmd) state_next = ST_OUT;
        else if (free_head[LW-1]) state_next = ST_OUT;
        else state_next = ST_GET_R;
      end
      ST_GET_R:     state_next = (eff_app && head_ok) ? ST_WALK : ST_RD_A;
      ST_WALK:      state_next = ST_WAIT_WALK;
      ST_WAIT_WALK: state_next = walk_end ? ST_RD_A : ST_WALK;
      ST_RD_A:      state_next = ST_RD_B;
      ST_RD_B:      state_next = ST_WAIT_B;
      ST_WAIT_B:    state_next = ST_WR_A;
      ST_WR_A:      state_next = ST_WR_B;
      ST_WR_B:      state_next = ST_WR_SELF;
      ST_WR_SELF:   state_next = ST_OUT;
      ST_OUT:       if (!o_valid || !res_stall) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Plan of link updates: neighbor A, neighbor B and the self entry
  // (granted block, or the freed target).
  logic [AW-1:0] nb_a, nb_b, self_a;
  logic          nb_a_en, nb_b_en;
  logic [EW-1:0] nb_a_data, nb_b_data, self_ent;

  always_comb begin
    nb_a = '0; nb_a_en = 1'b0; nb_b = '0; nb_b_en = 1'b0;
    nb_a_data = a_ent; nb_b_data = b_ent;
    self_a = r; self_ent = {1'b1, NIL, NIL};
    if (is_free) begin
      // A: next neighbor gets prev = p; B: prev neighbor gets next = n
      self_a = tgt; self_ent = {1'b0, NIL, free_head};
      nb_a = n_of[AW-1:0]; nb_a_en = !n_of[LW-1];
      nb_a_data = {a_ent[EW-1], p_of, a_ent[LW-1:0]};
      nb_b = p_of[AW-1:0]; nb_b_en = !p_of[LW-1];
      nb_b_data = {b_ent[EW-1:LW], n_of};
    end else if (k == KIND_PREPEND) begin
      self_ent = {1'b1, NIL, head_ok ? lnk(head) : NIL};
      nb_a = head; nb_a_en = head_ok;
      nb_a_data = {a_ent[EW-1], lnk(r), a_ent[LW-1:0]};
    end else if (eff_app) begin
      self_ent = {1'b1, head_ok ? lnk(tail) : NIL, NIL};
      nb_a = tail; nb_a_en = head_ok;
      nb_a_data = {a_ent[EW-1:LW], lnk(r)};
    end else if (k == KIND_INS_BEF) begin
      self_ent = {1'b1, p_of, lnk(tgt)};
      nb_a = tgt; nb_a_en = 1'b1;
      nb_a_data = {a_ent[EW-1], lnk(r), a_ent[LW-1:0]};
      nb_b = p_of[AW-1:0]; nb_b_en = !p_of[LW-1];
      nb_b_data = {b_ent[EW-1:LW], lnk(r)};
    end else if (k == KIND_INS_AFT) begin
      self_ent = {1'b1, lnk(tgt), n_of};
      nb_a = tgt; nb_a_en = 1'b1;
      nb_a_data = {a_ent[EW-1:LW], lnk(r)};
      nb_b = n_of[AW-1:0]; nb_b_en = !n_of[LW-1];
      nb_b_data = {b_ent[EW-1], lnk(r), b_ent[LW-1:0]};
    end
  end

  // memory port
  always_comb begin
    we = 1'b0; addr = '0; wdata = '0;
    unique case (state)
      ST_SWEEP: begin
        we = 1'b1; addr = sweep[AW-1:0];
        wdata = {1'b0, NIL, (sweep == LAST) ? NIL : lnk(AW'(sweep + 1'b1))};
      end
      ST_RD_HEAD: addr = head;
      ST_RD_TGT:  addr = tgt;
      ST_DECIDE:  addr = free_head[AW-1:0];
      ST_WALK:    addr = cur;
      ST_RD_A:    addr = nb_a;
      ST_RD_B:    addr = nb_b;
      ST_WR_A: begin
        we = nb_a_en; addr = nb_a; wdata = nb_a_data;
      end
      ST_WR_B: begin
        we = nb_b_en; addr = nb_b; wdata = nb_b_data;
      end
      ST_WR_SELF: begin
        we = 1'b1; addr = self_a; wdata = self_ent;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // free list starts at block 0
      state <= ST_SWEEP; sweep <= '0; free_head <= '0; o_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SWEEP) sweep <= sweep + 1'b1;
      o_valid <= out_go || (o_valid && res_stall);
      if (state == ST_GET_R) free_head <= rd_next;
      else if (state == ST_WR_SELF && is_free) free_head <= lnk(tgt);
    end
  end

  // payload / datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        k <= kind; hv_in <= list_head_valid; h_in <= list_head;
        tv_in <= target_valid; t_in <= target;
      end
      ST_RD_TGT: head_ok <= hv_in && h_range && rd_use;
      ST_DECIDE: begin
        tgt_ok <= tgt_c; n_of <= rd_next; p_of <= rd_prev;
        w_gv <= 1'b0; w_g <= 8'd0;
        if (is_free && !tgt_c) w_st <= STATUS_NOTGT;
        else if (is_cmd && free_head[LW-1]) w_st <= STATUS_EMPTY;
        else w_st <= STATUS_OK;
        // freeing a first element moves the head to its next link
        if (is_free && tgt_c && rd_prev[LW-1]) begin
          w_hv <= !rd_next[LW-1];
          w_h  <= rd_next[LW-1] ? 8'd0 : to8(rd_next[AW-1:0]);
        end else begin
          w_hv <= hv_in; w_h <= h_in;
        end
      end
      ST_GET_R: begin
        r <= free_head[AW-1:0]; w_gv <= 1'b1; w_g <= to8(free_head[AW-1:0]);
        cur <= head; tail <= head; steps <= '0;
        if (k == KIND_PREPEND || (eff_app && !head_ok) ||
            (k == KIND_INS_BEF && tgt_ok && p_of[LW-1])) begin
          w_hv <= 1'b1; w_h <= to8(free_head[AW-1:0]);
        end
      end
      ST_WAIT_WALK: begin
        if (walk_end) begin
          tail <= cur;
        end else begin
          cur <= rd_next[AW-1:0]; steps <= steps + 1'b1;
        end
      end
      ST_RD_B:   a_ent <= rdata;
      ST_WAIT_B: b_ent <= rdata;
      ST_OUT: begin
        if (out_go) begin
          status <= w_st; granted_valid <= w_gv; granted <= w_g;
          new_head_valid <= w_hv; new_head <= w_h;
        end
      end
      default: ;
    endcase
  end

endmodule

### design/pdl_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module pdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
